// ===== hw/rtl/rss_pkg.sv =====
// Shared types and constants for the REP string step pipeline.
// No dependencies; imported by every module of the block.
package rss_pkg;

  localparam logic [7:0] OPC_MOVSB = 8'hA4;
  localparam logic [7:0] OPC_MOVSW = 8'hA5;
  localparam logic [7:0] OPC_CMPSB = 8'hA6;
  localparam logic [7:0] OPC_CMPSW = 8'hA7;
  localparam logic [7:0] OPC_STOSB = 8'hAA;
  localparam logic [7:0] OPC_STOSW = 8'hAB;
  localparam logic [7:0] OPC_LODSB = 8'hAC;
  localparam logic [7:0] OPC_LODSW = 8'hAD;
  localparam logic [7:0] OPC_SCASB = 8'hAE;
  localparam logic [7:0] OPC_SCASW = 8'hAF;
  localparam logic [7:0] OPC_INSB  = 8'h6C;
  localparam logic [7:0] OPC_INSW  = 8'h6D;
  localparam logic [7:0] OPC_OUTSB = 8'h6E;
  localparam logic [7:0] OPC_OUTSW = 8'h6F;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ILLEGAL   = 2'd1,
    ST_SEG_FAULT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_MOVS,
    OP_CMPS,
    OP_STOS,
    OP_LODS,
    OP_SCAS,
    OP_INS,
    OP_OUTS,
    OP_ILLEGAL
  } op_cls_t;

  // decode stage -> execute stage
  typedef struct packed {
    logic        iter;
    logic        mw;
    logic        pw;
    logic        fw;
    logic        step_si;
    logic        step_di;
    logic        word;
    logic        down;
    logic        repe;
    status_t     status;
    logic [15:0] cx;
    logic [15:0] si;
    logic [15:0] di;
    logic [15:0] ax;
    logic [15:0] wdata;
    logic [15:0] op_a;
    logic [15:0] op_b;
  } dec_t;

  // execute stage -> flag/output stage
  typedef struct packed {
    logic        iter;
    logic        mw;
    logic        pw;
    logic        fw;
    logic        word;
    logic        repe;
    status_t     status;
    logic [15:0] cx;
    logic [15:0] si;
    logic [15:0] di;
    logic [15:0] ax;
    logic [15:0] wdata;
    logic [15:0] diff;
    logic        cf;
    logic        af;
    logic        of;
  } exe_t;

endpackage

// ===== hw/rtl/rss_decode.sv =====
// Stage 1: opcode decode, fault checks, operand and write data selection.
// Depends on rss_pkg.
module rss_decode import rss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [7:0]  opcode,
  input  logic        rep_mode,
  input  logic        direction,
  input  logic        segment_override,
  input  logic [15:0] count_in,
  input  logic [15:0] src_index,
  input  logic [15:0] dst_index,
  input  logic [15:0] acc,
  input  logic [15:0] src_data,
  input  logic [15:0] dst_data,
  input  logic [15:0] port_data,
  output logic        dec_valid,
  output dec_t        dec
);

  op_cls_t     cls;
  logic        word;
  logic [15:0] mask;
  dec_t        dec_next;

  always_comb begin
    unique case (opcode[7:1])
      OPC_MOVSB[7:1]: cls = OP_MOVS;
      OPC_CMPSB[7:1]: cls = OP_CMPS;
      OPC_STOSB[7:1]: cls = OP_STOS;
      OPC_LODSB[7:1]: cls = OP_LODS;
      OPC_SCASB[7:1]: cls = OP_SCAS;
      OPC_INSB[7:1]:  cls = OP_INS;
      OPC_OUTSB[7:1]: cls = OP_OUTS;
      default:        cls = OP_ILLEGAL;
    endcase
  end

  assign word = opcode[0];
  assign mask = word ? 16'hFFFF : 16'h00FF;

  always_comb begin
    dec_next         = '0;
    dec_next.word    = word;
    dec_next.down    = direction;
    dec_next.repe    = rep_mode;
    dec_next.cx      = count_in;
    dec_next.si      = src_index;
    dec_next.di      = dst_index;
    dec_next.ax      = acc;
    dec_next.status  = ST_OK;
    if (segment_override) begin
      dec_next.status = ST_SEG_FAULT;
    end else if (count_in != 16'd0) begin
      dec_next.iter = 1'b1;
      unique case (cls)
        OP_MOVS: begin
          dec_next.mw      = 1'b1;
          dec_next.wdata   = src_data & mask;
          dec_next.step_si = 1'b1;
          dec_next.step_di = 1'b1;
        end
        OP_CMPS: begin
          dec_next.fw      = 1'b1;
          dec_next.op_a    = src_data & mask;
          dec_next.op_b    = dst_data & mask;
          dec_next.step_si = 1'b1;
          dec_next.step_di = 1'b1;
        end
        OP_STOS: begin
          dec_next.mw      = 1'b1;
          dec_next.wdata   = acc & mask;
          dec_next.step_di = 1'b1;
        end
        OP_LODS: begin
          dec_next.ax      = word ? src_data : {acc[15:8], src_data[7:0]};
          dec_next.step_si = 1'b1;
        end
        OP_SCAS: begin
          dec_next.fw      = 1'b1;
          dec_next.op_a    = acc & mask;
          dec_next.op_b    = dst_data & mask;
          dec_next.step_di = 1'b1;
        end
        OP_INS: begin
          dec_next.mw      = 1'b1;
          dec_next.wdata   = port_data & mask;
          dec_next.step_di = 1'b1;
        end
        OP_OUTS: begin
          dec_next.pw      = 1'b1;
          dec_next.wdata   = src_data & mask;
          dec_next.step_si = 1'b1;
        end
        default: begin
          dec_next.iter   = 1'b0;
          dec_next.status = ST_ILLEGAL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (en) begin
      dec_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec <= dec_next;
    end
  end

endmodule

// ===== hw/rtl/rss_exec.sv =====
// Stage 2: compare subtract with carry, aux and overflow, index steps, count.
// Depends on rss_pkg.
module rss_exec import rss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic dec_valid,
  input  dec_t dec,
  output logic exe_valid,
  output exe_t exe
);

  logic [16:0] diff_full;
  logic [15:0] mask;
  logic [15:0] r;
  logic [15:0] step;
  logic [15:0] ovf;
  exe_t        exe_next;

  assign mask      = dec.word ? 16'hFFFF : 16'h00FF;
  assign step      = {14'd0, dec.word, ~dec.word};
  assign diff_full = {1'b0, dec.op_a} - {1'b0, dec.op_b};
  assign r         = diff_full[15:0] & mask;
  assign ovf       = (dec.op_a ^ dec.op_b) & (dec.op_a ^ r);

  always_comb begin
    exe_next        = '0;
    exe_next.iter   = dec.iter;
    exe_next.mw     = dec.mw;
    exe_next.pw     = dec.pw;
    exe_next.fw     = dec.fw;
    exe_next.word   = dec.word;
    exe_next.repe   = dec.repe;
    exe_next.status = dec.status;
    exe_next.ax     = dec.ax;
    exe_next.wdata  = dec.wdata;
    exe_next.diff   = r;
    exe_next.cf     = diff_full[16];
    exe_next.af     = dec.op_a[4] ^ dec.op_b[4] ^ r[4];
    exe_next.of     = dec.word ? ovf[15] : ovf[7];
    exe_next.cx     = dec.iter ? dec.cx - 16'd1 : dec.cx;
    exe_next.si     = dec.si;
    exe_next.di     = dec.di;
    if (dec.step_si) begin
      exe_next.si = dec.down ? dec.si - step : dec.si + step;
    end
    if (dec.step_di) begin
      exe_next.di = dec.down ? dec.di - step : dec.di + step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exe_valid <= 1'b0;
    end else if (en) begin
      exe_valid <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      exe <= exe_next;
    end
  end

endmodule

// ===== hw/rtl/rss_result.sv =====
// Stage 3: parity, zero and sign flags, repeat decision, output register.
// Depends on rss_pkg.
module rss_result import rss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        exe_valid,
  input  exe_t        exe,
  output logic        out_valid,
  output logic [15:0] new_count,
  output logic [15:0] new_src_index,
  output logic [15:0] new_dst_index,
  output logic [15:0] new_acc,
  output logic        mem_write,
  output logic        port_write,
  output logic [15:0] write_data,
  output logic        flags_written,
  output logic [5:0]  flags_out,
  output logic        repeat_again,
  output logic [1:0]  status
);

  logic       zf;
  logic       sf;
  logic       pf;
  logic       again_next;
  logic [5:0] flags_next;

  assign zf = (exe.diff == 16'd0);
  assign sf = exe.word ? exe.diff[15] : exe.diff[7];
  assign pf = ~^exe.diff[7:0];

  assign flags_next = exe.fw ? {exe.of, sf, zf, exe.af, pf, exe.cf} : 6'd0;
  assign again_next = exe.iter & (exe.fw ? (exe.repe ? zf : ~zf) : 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= exe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      new_count     <= exe.cx;
      new_src_index <= exe.si;
      new_dst_index <= exe.di;
      new_acc       <= exe.ax;
      mem_write     <= exe.mw;
      port_write    <= exe.pw;
      write_data    <= exe.wdata;
      flags_written <= exe.fw;
      flags_out     <= flags_next;
      repeat_again  <= again_next;
      status        <= exe.status;
    end
  end

endmodule

// ===== hw/rtl/x86_rep_string_step_unit.sv =====
// One iteration of an 8086 REP string instruction per beat, in three register
// stages: decode, subtract and index step, flags and result. A beat accepted
// on in_valid with in_stall low passes through those registers in order, and
// the unit takes a new beat every cycle; only out_stall slows it. Empty stages
// are filled while the output is held, so in_stall rises only when all three
// stages hold beats and the output is stalled. Depends on rss_pkg,
// rss_decode, rss_exec, rss_result.
module x86_rep_string_step_unit import rss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  opcode,
  input  logic        rep_mode,
  input  logic        direction,
  input  logic        segment_override,
  input  logic [15:0] count_in,
  input  logic [15:0] src_index,
  input  logic [15:0] dst_index,
  input  logic [15:0] acc,
  input  logic [15:0] src_data,
  input  logic [15:0] dst_data,
  input  logic [15:0] port_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] new_count,
  output logic [15:0] new_src_index,
  output logic [15:0] new_dst_index,
  output logic [15:0] new_acc,
  output logic        mem_write,
  output logic        port_write,
  output logic [15:0] write_data,
  output logic        flags_written,
  output logic [5:0]  flags_out,
  output logic        repeat_again,
  output logic [1:0]  status
);

  logic dec_valid;
  logic exe_valid;
  logic en1;
  logic en2;
  logic en3;
  dec_t dec;
  exe_t exe;

  assign en3      = ~out_valid | ~out_stall;
  assign en2      = ~exe_valid | en3;
  assign en1      = ~dec_valid | en2;
  assign in_stall = ~en1;

  rss_decode u_decode (
    .clk              (clk),
    .rst              (rst),
    .en               (en1),
    .in_valid         (in_valid),
    .opcode           (opcode),
    .rep_mode         (rep_mode),
    .direction        (direction),
    .segment_override (segment_override),
    .count_in         (count_in),
    .src_index        (src_index),
    .dst_index        (dst_index),
    .acc              (acc),
    .src_data         (src_data),
    .dst_data         (dst_data),
    .port_data        (port_data),
    .dec_valid        (dec_valid),
    .dec              (dec)
  );

  rss_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .en        (en2),
    .dec_valid (dec_valid),
    .dec       (dec),
    .exe_valid (exe_valid),
    .exe       (exe)
  );

  rss_result u_result (
    .clk           (clk),
    .rst           (rst),
    .en            (en3),
    .exe_valid     (exe_valid),
    .exe           (exe),
    .out_valid     (out_valid),
    .new_count     (new_count),
    .new_src_index (new_src_index),
    .new_dst_index (new_dst_index),
    .new_acc       (new_acc),
    .mem_write     (mem_write),
    .port_write    (port_write),
    .write_data    (write_data),
    .flags_written (flags_written),
    .flags_out     (flags_out),
    .repeat_again  (repeat_again),
    .status        (status)
  );

endmodule

// ===== hw/rtl/rss_checker.sv =====
// Port-level checks for the REP string step unit, bound to the top level.
// Depends on rss_pkg and x86_rep_string_step_unit.
module rss_checker import rss_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        mem_write,
  input logic        port_write,
  input logic [15:0] write_data,
  input logic        flags_written,
  input logic [5:0]  flags_out,
  input logic        repeat_again,
  input logic [1:0]  status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(write_data) && $stable(status))
    else $error("output beat changed while stalled");

  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      !mem_write && !port_write && !flags_written && !repeat_again)
    else $error("faulted beat requests work");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(mem_write && port_write))
    else $error("memory and port write together");

  a_flags_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !flags_written |-> flags_out == 6'd0)
    else $error("flags set without flag update");

  a_wdata_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mem_write && !port_write |-> write_data == 16'd0)
    else $error("write data without a write");

endmodule

bind x86_rep_string_step_unit rss_checker u_rss_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .mem_write     (mem_write),
  .port_write    (port_write),
  .write_data    (write_data),
  .flags_written (flags_written),
  .flags_out     (flags_out),
  .repeat_again  (repeat_again),
  .status        (status)
);

// ===== tb/rss_step_checker.sv =====
`timescale 1ns / 100ps
// Checker for x86_rep_string_step_unit: watches both valid/stall channels,
// predicts each string iteration and compares every result beat in order.
// Depends on rss_pkg for the opcode constants and status codes.
module rss_step_checker import rss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  opcode,
  input  logic        rep_mode,
  input  logic        direction,
  input  logic        segment_override,
  input  logic [15:0] count_in,
  input  logic [15:0] src_index,
  input  logic [15:0] dst_index,
  input  logic [15:0] acc,
  input  logic [15:0] src_data,
  input  logic [15:0] dst_data,
  input  logic [15:0] port_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] new_count,
  input  logic [15:0] new_src_index,
  input  logic [15:0] new_dst_index,
  input  logic [15:0] new_acc,
  input  logic        mem_write,
  input  logic        port_write,
  input  logic [15:0] write_data,
  input  logic        flags_written,
  input  logic [5:0]  flags_out,
  input  logic        repeat_again,
  input  logic [1:0]  status,
  output int          mismatches,
  output int          outstanding,
  output int          checked
);

  typedef struct packed {
    logic [15:0] count;
    logic [15:0] src_idx;
    logic [15:0] dst_idx;
    logic [15:0] accum;
    logic        mem_wr;
    logic        port_wr;
    logic [15:0] wdata;
    logic        fw;
    logic [5:0]  flags;
    logic        again;
    status_t     st;
  } iter_result_t;

  iter_result_t pending_results[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    checked     = 0;
  end

  // CF PF AF ZF SF OF of a - b at byte or word size; a and b already masked
  function automatic logic [5:0] compare_flags(input logic [15:0] a, b, input logic word);
    logic [15:0] diff;
    logic [5:0]  f;
    diff = word ? (a - b) : ((a - b) & 16'h00FF);
    f[0] = a < b;
    f[1] = ~^diff[7:0];
    f[2] = a[4] ^ b[4] ^ diff[4];
    f[3] = diff == 16'd0;
    f[4] = word ? diff[15] : diff[7];
    f[5] = word ? ((a[15] ^ b[15]) & (a[15] ^ diff[15]))
                : ((a[7] ^ b[7]) & (a[7] ^ diff[7]));
    return f;
  endfunction

  function automatic iter_result_t rep_iteration(
    input logic [7:0]  op,
    input logic        repe, down, ovr,
    input logic [15:0] cx, si, di, ax, src, dst, port
  );
    iter_result_t r;
    logic         word;
    logic [15:0]  mask;
    logic [15:0]  stride;
    logic         step_si;
    logic         step_di;
    logic         legal;
    r         = '0;
    r.count   = cx;
    r.src_idx = si;
    r.dst_idx = di;
    r.accum   = ax;
    r.st      = ST_OK;
    word      = op[0];
    mask      = word ? 16'hFFFF : 16'h00FF;
    stride    = word ? 16'd2 : 16'd1;
    step_si   = 1'b0;
    step_di   = 1'b0;
    legal     = 1'b1;
    if (ovr) begin
      r.st = ST_SEG_FAULT;
    end else if (cx != 16'd0) begin
      case (op)
        OPC_MOVSB, OPC_MOVSW: begin
          r.mem_wr = 1'b1;
          r.wdata  = src & mask;
          step_si  = 1'b1;
          step_di  = 1'b1;
        end
        OPC_CMPSB, OPC_CMPSW: begin
          r.fw    = 1'b1;
          r.flags = compare_flags(src & mask, dst & mask, word);
          step_si = 1'b1;
          step_di = 1'b1;
        end
        OPC_STOSB, OPC_STOSW: begin
          r.mem_wr = 1'b1;
          r.wdata  = ax & mask;
          step_di  = 1'b1;
        end
        OPC_LODSB: begin
          r.accum = {ax[15:8], src[7:0]};
          step_si = 1'b1;
        end
        OPC_LODSW: begin
          r.accum = src;
          step_si = 1'b1;
        end
        OPC_SCASB, OPC_SCASW: begin
          r.fw    = 1'b1;
          r.flags = compare_flags(ax & mask, dst & mask, word);
          step_di = 1'b1;
        end
        OPC_INSB, OPC_INSW: begin
          r.mem_wr = 1'b1;
          r.wdata  = port & mask;
          step_di  = 1'b1;
        end
        OPC_OUTSB, OPC_OUTSW: begin
          r.port_wr = 1'b1;
          r.wdata   = src & mask;
          step_si   = 1'b1;
        end
        default: begin
          legal = 1'b0;
          r.st  = ST_ILLEGAL;
        end
      endcase
      if (legal) begin
        r.count = cx - 16'd1;
        if (step_si) r.src_idx = down ? si - stride : si + stride;
        if (step_di) r.dst_idx = down ? di - stride : di + stride;
        // REPE goes on while ZF set, REPNE while clear
        r.again = r.fw ? (repe == r.flags[3]) : 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want, got);
    if (want !== got) begin
      mismatches = mismatches + 1;
      if (mismatches <= 10)
        $display("mismatch: %s of result %0d expected %h, got %h", field, checked, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    iter_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        pending_results.push_back(rep_iteration(opcode, rep_mode, direction,
          segment_override, count_in, src_index, dst_index, acc, src_data,
          dst_data, port_data));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: result beat with nothing expected, count %h", new_count);
        end else begin
          want = pending_results.pop_front();
          check_field("new_count", want.count, new_count);
          check_field("new_src_index", want.src_idx, new_src_index);
          check_field("new_dst_index", want.dst_idx, new_dst_index);
          check_field("new_acc", want.accum, new_acc);
          check_field("mem_write", {15'd0, want.mem_wr}, {15'd0, mem_write});
          check_field("port_write", {15'd0, want.port_wr}, {15'd0, port_write});
          check_field("write_data", want.wdata, write_data);
          check_field("flags_written", {15'd0, want.fw}, {15'd0, flags_written});
          check_field("flags_out", {10'd0, want.flags}, {10'd0, flags_out});
          check_field("repeat_again", {15'd0, want.again}, {15'd0, repeat_again});
          check_field("status", {14'd0, want.st}, {14'd0, status});
          checked = checked + 1;
        end
      end
      outstanding = pending_results.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the x86_rep_string_step_unit testbench: clock, reset, directed and
// random iteration beats under several idle/stall mixes, and the verdict.
// Depends on rss_pkg, the unit itself and rss_step_checker.
module testbench import rss_pkg::*;;

  typedef struct {
    logic [7:0]  op;
    logic        rep;
    logic        dir;
    logic        ovr;
    logic [15:0] cx;
    logic [15:0] si;
    logic [15:0] di;
    logic [15:0] ax;
    logic [15:0] src;
    logic [15:0] dst;
    logic [15:0] port;
  } beat_t;

  logic        clk              = 1'b0;
  logic        rst              = 1'b1;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [7:0]  opcode           = 8'd0;
  logic        rep_mode         = 1'b0;
  logic        direction        = 1'b0;
  logic        segment_override = 1'b0;
  logic [15:0] count_in         = 16'd0;
  logic [15:0] src_index        = 16'd0;
  logic [15:0] dst_index        = 16'd0;
  logic [15:0] acc              = 16'd0;
  logic [15:0] src_data         = 16'd0;
  logic [15:0] dst_data         = 16'd0;
  logic [15:0] port_data        = 16'd0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [15:0] new_count;
  logic [15:0] new_src_index;
  logic [15:0] new_dst_index;
  logic [15:0] new_acc;
  logic        mem_write;
  logic        port_write;
  logic [15:0] write_data;
  logic        flags_written;
  logic [5:0]  flags_out;
  logic        repeat_again;
  logic [1:0]  status;
  int          mismatches;
  int          outstanding;
  int          checked;

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int directed_sent   = 0;
  int random_sent     = 0;

  x86_rep_string_step_unit i_dut (.*);

  rss_step_checker i_checker (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic beat_t make_beat(
    input logic [7:0]  op,
    input logic        rep, dir, ovr,
    input logic [15:0] cx, si, di, ax, src, dst, port
  );
    beat_t b;
    b.op   = op;
    b.rep  = rep;
    b.dir  = dir;
    b.ovr  = ovr;
    b.cx   = cx;
    b.si   = si;
    b.di   = di;
    b.ax   = ax;
    b.src  = src;
    b.dst  = dst;
    b.port = port;
    return b;
  endfunction

  function automatic logic [15:0] random_index();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0:       return 16'h0000;
        1:       return 16'h0001;
        2:       return 16'hFFFE;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom_range(65535));
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    int    pick;
    b.src  = 16'($urandom_range(65535));
    b.dst  = 16'($urandom_range(65535));
    b.port = 16'($urandom_range(65535));
    b.ax   = 16'($urandom_range(65535));
    b.si   = random_index();
    b.di   = random_index();
    b.rep  = 1'($urandom_range(1));
    b.dir  = 1'($urandom_range(1));
    b.ovr  = ($urandom_range(99) < 4);
    if ($urandom_range(99) < 85) begin
      case ($urandom_range(13))
        0:       b.op = OPC_MOVSB;
        1:       b.op = OPC_MOVSW;
        2:       b.op = OPC_CMPSB;
        3:       b.op = OPC_CMPSW;
        4:       b.op = OPC_STOSB;
        5:       b.op = OPC_STOSW;
        6:       b.op = OPC_LODSB;
        7:       b.op = OPC_LODSW;
        8:       b.op = OPC_SCASB;
        9:       b.op = OPC_SCASW;
        10:      b.op = OPC_INSB;
        11:      b.op = OPC_INSW;
        12:      b.op = OPC_OUTSB;
        default: b.op = OPC_OUTSW;
      endcase
    end else begin
      b.op = 8'($urandom_range(255));
    end
    pick = $urandom_range(99);
    if (pick < 6)       b.cx = 16'd0;
    else if (pick < 16) b.cx = 16'd1;
    else if (pick < 50) b.cx = 16'($urandom_range(16));
    else                b.cx = 16'($urandom_range(65535));
    // matching operands so compares hit ZF both ways
    if ($urandom_range(99) < 30)
      b.dst = (b.op == OPC_SCASB || b.op == OPC_SCASW) ? b.ax : b.src;
    return b;
  endfunction

  task automatic send_iteration(input beat_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    opcode           <= b.op;
    rep_mode         <= b.rep;
    direction        <= b.dir;
    segment_override <= b.ovr;
    count_in         <= b.cx;
    src_index        <= b.si;
    dst_index        <= b.di;
    acc              <= b.ax;
    src_data         <= b.src;
    dst_data         <= b.dst;
    port_data        <= b.port;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    beat_t directed[$];
    int    phase;
    int    n;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed.push_back(make_beat(OPC_MOVSB, 1'b0, 1'b0, 1'b0, 16'h0001, 16'hFFFF, 16'h0000,
                                 16'h0000, 16'hA55A, 16'h0000, 16'h0000));
    directed.push_back(make_beat(OPC_MOVSW, 1'b1, 1'b1, 1'b0, 16'hFFFF, 16'h0001, 16'h0000,
                                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(make_beat(OPC_CMPSB, 1'b1, 1'b0, 1'b0, 16'h0002, 16'h1000, 16'h2000,
                                 16'h0000, 16'h1234, 16'h5634, 16'h0000));
    directed.push_back(make_beat(OPC_CMPSB, 1'b0, 1'b1, 1'b0, 16'h0002, 16'h0000, 16'h0000,
                                 16'h0000, 16'h00FF, 16'h00FF, 16'h0000));
    directed.push_back(make_beat(OPC_CMPSW, 1'b1, 1'b0, 1'b0, 16'h0010, 16'hFFFE, 16'hFFFF,
                                 16'h0000, 16'h8000, 16'h0001, 16'h0000));
    directed.push_back(make_beat(OPC_CMPSW, 1'b0, 1'b1, 1'b0, 16'h0003, 16'h0001, 16'h0000,
                                 16'h0000, 16'h0000, 16'hFFFF, 16'h0000));
    directed.push_back(make_beat(OPC_STOSB, 1'b0, 1'b0, 1'b0, 16'h0001, 16'h0000, 16'hFFFF,
                                 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(make_beat(OPC_STOSW, 1'b1, 1'b1, 1'b0, 16'h8000, 16'h1234, 16'h0001,
                                 16'h8001, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(make_beat(OPC_LODSB, 1'b0, 1'b0, 1'b0, 16'h0005, 16'hFFFF, 16'h0000,
                                 16'h1234, 16'hABCD, 16'h0000, 16'h0000));
    directed.push_back(make_beat(OPC_LODSW, 1'b1, 1'b1, 1'b0, 16'h0001, 16'h0000, 16'h0000,
                                 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
    directed.push_back(make_beat(OPC_SCASB, 1'b1, 1'b0, 1'b0, 16'h0001, 16'h0000, 16'hFFFF,
                                 16'h0080, 16'h0000, 16'h0001, 16'h0000));
    directed.push_back(make_beat(OPC_SCASW, 1'b0, 1'b1, 1'b0, 16'h0004, 16'h0000, 16'h0000,
                                 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
    directed.push_back(make_beat(OPC_INSB, 1'b0, 1'b0, 1'b0, 16'h0002, 16'h4444, 16'hFFFF,
                                 16'h0000, 16'h0000, 16'h0000, 16'h7F80));
    directed.push_back(make_beat(OPC_INSW, 1'b1, 1'b1, 1'b0, 16'h0002, 16'h4444, 16'h0000,
                                 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    directed.push_back(make_beat(OPC_OUTSB, 1'b0, 1'b0, 1'b0, 16'h0001, 16'hFFFF, 16'h5555,
                                 16'h0000, 16'h00FF, 16'h0000, 16'hFFFF));
    directed.push_back(make_beat(OPC_OUTSW, 1'b1, 1'b1, 1'b0, 16'h0007, 16'h0000, 16'h5555,
                                 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
    directed.push_back(make_beat(OPC_MOVSW, 1'b1, 1'b1, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(make_beat(8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h1111, 16'h2222,
                                 16'h3333, 16'h4444, 16'h5555, 16'h6666));
    directed.push_back(make_beat(OPC_MOVSB, 1'b0, 1'b0, 1'b1, 16'h0005, 16'h0010, 16'h0020,
                                 16'h0030, 16'h0040, 16'h0050, 16'h0060));
    directed.push_back(make_beat(8'hFF, 1'b1, 1'b1, 1'b1, 16'h0000, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(make_beat(8'h00, 1'b0, 1'b0, 1'b0, 16'h0001, 16'h0000, 16'h0000,
                                 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(make_beat(8'hFF, 1'b1, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(make_beat(8'hA8, 1'b0, 1'b0, 1'b0, 16'h0003, 16'h0100, 16'h0200,
                                 16'h0300, 16'h0400, 16'h0500, 16'h0600));
    directed.push_back(make_beat(8'h6B, 1'b1, 1'b0, 1'b0, 16'h0002, 16'h0100, 16'h0200,
                                 16'h0300, 16'h0400, 16'h0500, 16'h0600));
    directed.push_back(make_beat(8'h70, 1'b0, 1'b1, 1'b0, 16'h0009, 16'h0100, 16'h0200,
                                 16'h0300, 16'h0400, 16'h0500, 16'h0600));

    foreach (directed[i]) begin
      send_iteration(directed[i]);
      directed_sent++;
    end
    drain_results();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
        1:       begin sender_idle_pct = 71; stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  stall_pct = 71; end
        default: begin sender_idle_pct = 6;  stall_pct = 6;  end
      endcase
      for (n = 0; n < 412; n++) begin
        send_iteration(random_beat());
        random_sent++;
      end
      drain_results();
    end

    stall_pct = 0;
    repeat (10) @(negedge clk);
    $display("summary: %0d directed and %0d random beats sent, %0d results compared",
             directed_sent, random_sent, checked);
    $display("summary: all string opcodes in both sizes, illegal opcodes, zero counts, %s",
             "segment faults, four idle/stall mixes");
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
